// ===== rtl/msrr_pkg.sv =====
// Shared types, codes and the CRC step of the Modbus register responder.
`default_nettype none
package msrr_pkg;
	localparam logic [7:0] FC_READ = 8'h03;
	localparam logic [7:0] FC_WRITE = 8'h10;
	localparam logic [7:0] EXC_ADDRESS = 8'h02;
	localparam logic [7:0] EXC_VALUE = 8'h03;
	localparam logic [15:0] MAX_READ_QTY = 16'd125;
	localparam logic [15:0] MAX_WRITE_QTY = 16'd123;
	localparam logic [15:0] ALARM_FIRST = 16'h000C;
	localparam logic [15:0] ALARM_LAST = 16'h0013;
	localparam logic [15:0] TEMP_CORR_REG = 16'h001D;
	localparam logic [15:0] HUM_CORR_REG = 16'h001E;

	localparam logic [1:0] CFG_DEV_TYPE = 2'd0;
	localparam logic [1:0] CFG_FW_VER = 2'd1;
	localparam logic [1:0] CFG_ID_HIGH = 2'd2;
	localparam logic [1:0] CFG_ID_LOW = 2'd3;

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_EXC = 2'd2;

	typedef struct packed {
		logic take;
		logic eval;
		logic advance;
	} dp_cmd_t;

	typedef struct packed {
		logic respond;
		logic last;
	} dp_stat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ 16'hA001;
			else
				c = c >> 1;
		end
		return c;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/modbus_sensor_register_responder.sv =====
// Top level of the Modbus read/write register responder.
// Usage:
//  - Request channel (req_valid/req_ready): one frame byte per request, CRC
//    already stripped; req_end marks the last byte. humidity and temperature
//    are sampled with each request; the values on the last byte are served.
//  - A request is taken only while idle. After the last byte an evaluation
//    state checks quantity and addresses and commits writes.
//  - Response channel (resp_valid/resp_ready): 5 to 29 bytes, CRC low byte
//    first, resp_end on the last. One byte per cycle while resp_ready is
//    high; CRC is accumulated one byte per cycle as bytes leave.
//  - After the last byte, an evaluation state comes before the first response
//    byte; no request is taken until the response ends. The response burst
//    is set by the byte sequencer in the datapath.
//  - Function codes other than 03 and 16 produce no response.
//  - While the receiver stalls, the current byte holds and no request is
//    taken.
//  - Reset clears config, alarm and correction words and the frame parser.
//  - cfg_we writes device_type, firmware_version, id high, id low (0..3).
`default_nettype none
module modbus_sensor_register_responder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire logic [7:0] req_byte,
	input wire logic req_end,
	input wire logic [15:0] humidity,
	input wire logic signed [15:0] temperature,
	output logic resp_valid,
	input wire logic resp_ready,
	output logic [7:0] resp_byte,
	output logic resp_end,
	output logic signed [15:0] temp_correction,
	output logic signed [15:0] humidity_correction,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import msrr_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t st;

	msrr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_end(req_end),
		.resp_valid(resp_valid),
		.resp_ready(resp_ready),
		.cmd(cmd),
		.st(st)
	);

	msrr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.req_byte(req_byte),
		.req_end(req_end),
		.humidity(humidity),
		.temperature(temperature),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.resp_byte(resp_byte),
		.resp_end(resp_end),
		.temp_correction(temp_correction),
		.humidity_correction(humidity_correction)
	);
endmodule
`default_nettype wire

// ===== rtl/msrr_ctrl.sv =====
// Controller: request intake, frame evaluation and response byte sequencing.
`default_nettype none
module msrr_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire logic req_end,
	output logic resp_valid,
	input wire logic resp_ready,
	output msrr_pkg::dp_cmd_t cmd,
	input wire msrr_pkg::dp_stat_t st
);
	import msrr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;

	assign req_ready = (state_q == ST_IDLE);
	assign resp_valid = (state_q == ST_EMIT);

	always_comb begin
		cmd.take = req_valid && req_ready;
		cmd.eval = (state_q == ST_EVAL);
		cmd.advance = resp_valid && resp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && req_end)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= st.respond ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (resp_ready && st.last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/msrr_dp.sv =====
// Datapath: frame fields, staged writes, register map, response bytes and CRC.
`default_nettype none
module msrr_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire msrr_pkg::dp_cmd_t cmd,
	output msrr_pkg::dp_stat_t st,
	input wire logic [7:0] req_byte,
	input wire logic req_end,
	input wire logic [15:0] humidity,
	input wire logic signed [15:0] temperature,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	output logic [7:0] resp_byte,
	output logic resp_end,
	output logic signed [15:0] temp_correction,
	output logic signed [15:0] humidity_correction
);
	import msrr_pkg::*;

	logic [15:0] dev_type_q, fw_ver_q, id_high_q, id_low_q;
	logic [15:0] alarm_q [8];
	logic [15:0] corr_q [2];
	logic [15:0] stage_q [8];
	logic [7:0] svalid_q;
	logic [7:0] pos_q, addr_q, func_q;
	logic [15:0] start_q, qty_q;
	logic [15:0] hum_q, temp_q;
	logic [1:0] kind_q;
	logic [7:0] exc_q;
	logic [4:0] len_q, idx_q;
	logic [15:0] crc_q;

	logic [3:0] rel;
	logic [16:0] last_reg;
	logic rd_qty_ok, wr_qty_ok, rd_addr_ok, wr_addr_ok;
	logic [4:0] off;
	logic [15:0] rreg, rword;
	logic [7:0] body_byte;

	assign rel = pos_q[3:0] - 4'd7;
	assign last_reg = {1'b0, start_q} + {1'b0, qty_q} - 17'd1;
	assign rd_qty_ok = (qty_q != 16'd0) && (qty_q <= MAX_READ_QTY);
	assign wr_qty_ok = (qty_q != 16'd0) && (qty_q <= MAX_WRITE_QTY);
	assign rd_addr_ok = (start_q <= 16'd1 && last_reg <= 17'd1) ||
		(start_q >= 16'd8 && start_q <= ALARM_LAST && last_reg <= {1'b0, ALARM_LAST});
	assign wr_addr_ok = (start_q >= ALARM_FIRST && start_q <= ALARM_LAST &&
		last_reg <= {1'b0, ALARM_LAST}) ||
		(start_q >= TEMP_CORR_REG && start_q <= HUM_CORR_REG &&
		last_reg <= {1'b0, HUM_CORR_REG});

	assign st.respond = (func_q == FC_READ) || (func_q == FC_WRITE);
	assign st.last = (idx_q == len_q + 5'd1);
	assign resp_end = st.last;
	assign temp_correction = corr_q[0];
	assign humidity_correction = corr_q[1];

	// read word selection for the current data byte
	assign off = idx_q - 5'd3;
	assign rreg = start_q + {12'd0, off[4:1]};

	always_comb begin
		case (rreg)
			16'h0000: rword = hum_q;
			16'h0001: rword = temp_q;
			16'h0008: rword = dev_type_q;
			16'h0009: rword = fw_ver_q;
			16'h000A: rword = id_high_q;
			16'h000B: rword = id_low_q;
			default: rword = alarm_q[rreg[2:0] - ALARM_FIRST[2:0]];
		endcase
	end

	always_comb begin
		body_byte = 8'h00;
		if (idx_q == 5'd0) begin
			body_byte = addr_q;
		end else if (idx_q == 5'd1) begin
			body_byte = (kind_q == KIND_EXC) ? (func_q | 8'h80) : func_q;
		end else begin
			unique case (kind_q)
				KIND_EXC: body_byte = exc_q;
				KIND_WRITE: begin
					case (idx_q)
						5'd2: body_byte = start_q[15:8];
						5'd3: body_byte = start_q[7:0];
						5'd4: body_byte = qty_q[15:8];
						default: body_byte = qty_q[7:0];
					endcase
				end
				KIND_READ: begin
					if (idx_q == 5'd2)
						body_byte = {qty_q[6:0], 1'b0};
					else
						body_byte = off[0] ? rword[7:0] : rword[15:8];
				end
				default: body_byte = 8'h00;
			endcase
		end
	end

	always_comb begin
		if (idx_q == len_q)
			resp_byte = crc_q[7:0];
		else if (idx_q == len_q + 5'd1)
			resp_byte = crc_q[15:8];
		else
			resp_byte = body_byte;
	end

	// configuration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_type_q <= '0;
			fw_ver_q <= '0;
			id_high_q <= '0;
			id_low_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEV_TYPE: dev_type_q <= cfg_data;
				CFG_FW_VER: fw_ver_q <= cfg_data;
				CFG_ID_HIGH: id_high_q <= cfg_data;
				CFG_ID_LOW: id_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// staged value payload and sensor samples, no reset
	always_ff @(posedge clk) begin
		if (cmd.take && pos_q >= 8'd7 && pos_q <= 8'd22) begin
			if (!rel[0])
				stage_q[rel[3:1]] <= {req_byte, 8'h00};
			else
				stage_q[rel[3:1]][7:0] <= req_byte;
		end
		if (cmd.take) begin
			hum_q <= humidity;
			temp_q <= temperature;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			addr_q <= '0;
			func_q <= '0;
			start_q <= '0;
			qty_q <= '0;
			svalid_q <= '0;
			kind_q <= KIND_READ;
			exc_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			crc_q <= 16'hFFFF;
			for (int i = 0; i < 8; i++)
				alarm_q[i] <= '0;
			corr_q[0] <= '0;
			corr_q[1] <= '0;
		end else begin
			if (cmd.take) begin
				if (pos_q == 8'd0) begin
					addr_q <= req_byte;
					func_q <= '0;
					start_q <= '0;
					qty_q <= '0;
					svalid_q <= '0;
				end else if (pos_q == 8'd1) func_q <= req_byte;
				else if (pos_q == 8'd2) start_q[15:8] <= req_byte;
				else if (pos_q == 8'd3) start_q[7:0] <= req_byte;
				else if (pos_q == 8'd4) qty_q[15:8] <= req_byte;
				else if (pos_q == 8'd5) qty_q[7:0] <= req_byte;
				else if (pos_q >= 8'd7 && pos_q <= 8'd22 && rel[0])
					svalid_q[rel[3:1]] <= 1'b1;
				if (req_end)
					pos_q <= '0;
				else if (pos_q != 8'hFF)
					pos_q <= pos_q + 8'd1;
			end
			if (cmd.eval) begin
				idx_q <= '0;
				crc_q <= 16'hFFFF;
				if (func_q == FC_READ) begin
					if (!rd_qty_ok) begin
						kind_q <= KIND_EXC; exc_q <= EXC_VALUE; len_q <= 5'd3;
					end else if (!rd_addr_ok) begin
						kind_q <= KIND_EXC; exc_q <= EXC_ADDRESS; len_q <= 5'd3;
					end else begin
						kind_q <= KIND_READ;
						len_q <= 5'd3 + {qty_q[3:0], 1'b0};
					end
				end else begin
					if (!wr_qty_ok) begin
						kind_q <= KIND_EXC; exc_q <= EXC_VALUE; len_q <= 5'd3;
					end else if (!wr_addr_ok) begin
						kind_q <= KIND_EXC; exc_q <= EXC_ADDRESS; len_q <= 5'd3;
					end else begin
						kind_q <= KIND_WRITE;
						len_q <= 5'd6;
					end
				end
				// commit staged writes
				if (func_q == FC_WRITE && wr_qty_ok && wr_addr_ok) begin
					for (int i = 0; i < 8; i++) begin
						if (qty_q > 16'(i) && svalid_q[i]) begin
							if (start_q + 16'(i) <= ALARM_LAST)
								alarm_q[3'(start_q + 16'(i) - ALARM_FIRST)] <= stage_q[i];
							else if (start_q + 16'(i) == TEMP_CORR_REG)
								corr_q[0] <= stage_q[i];
							else
								corr_q[1] <= stage_q[i];
						end
					end
				end
			end
			if (cmd.advance) begin
				idx_q <= idx_q + 5'd1;
				if (idx_q < len_q)
					crc_q <= crc_byte(crc_q, resp_byte);
			end
		end
	end
endmodule
`default_nettype wire

// ===== sim/msrr_frame_checker.sv =====
// Checker for the Modbus register responder: predicts response bytes and compares them.
`timescale 1ns / 1ps
`default_nettype none
module msrr_frame_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic [7:0] req_byte,
	input wire logic req_end,
	input wire logic [15:0] humidity,
	input wire logic signed [15:0] temperature,
	input wire logic resp_valid,
	input wire logic resp_ready,
	input wire logic [7:0] resp_byte,
	input wire logic resp_end,
	input wire logic signed [15:0] temp_correction,
	input wire logic signed [15:0] humidity_correction,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	output int fail_count,
	output int pending_bytes,
	output int resp_frames
);
	import msrr_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic [15:0] tcorr;
		logic [15:0] hcorr;
	} resp_item_t;

	resp_item_t expected_resp[$];
	logic [15:0] cfg_words[4];
	logic [15:0] alarm_words[8];
	logic [15:0] corr_words[2];
	logic [15:0] staged[8];
	logic [7:0] staged_valid;
	logic [7:0] pos;
	logic [7:0] fn_code;
	logic [7:0] slave_addr;
	logic [15:0] first_reg;
	logic [15:0] qty;

	assign pending_bytes = expected_resp.size();

	function automatic logic reg_readable(input logic [15:0] r);
		return r == 16'h0000 || r == 16'h0001 || (r >= 16'h0008 && r <= 16'h000B) ||
			(r >= ALARM_FIRST && r <= ALARM_LAST);
	endfunction

	function automatic logic [15:0] reg_value(input logic [15:0] r, input logic [15:0] hum,
			input logic [15:0] tmp);
		if (r == 16'h0000) return hum;
		if (r == 16'h0001) return tmp;
		if (r >= 16'h0008 && r <= 16'h000B) return cfg_words[r[1:0]];
		return alarm_words[3'(r - ALARM_FIRST)];
	endfunction

	function automatic logic reg_writable(input logic [15:0] r);
		return (r >= ALARM_FIRST && r <= ALARM_LAST) || r == TEMP_CORR_REG || r == HUM_CORR_REG;
	endfunction

	// Builds the response frame for a completed request and queues its bytes.
	task automatic close_frame(input logic [15:0] hum, input logic [15:0] tmp);
		logic [7:0] fr[$];
		logic [15:0] crc;
		logic ok;
		logic [15:0] r;
		int lim;
		fr = {};
		ok = 1'b1;
		if (fn_code == FC_READ) begin
			if (qty == 0 || qty > MAX_READ_QTY) begin
				fr = {slave_addr, FC_READ | 8'h80, EXC_VALUE};
			end else begin
				for (int i = 0; i < qty; i++)
					if (!reg_readable(first_reg + 16'(i))) ok = 1'b0;
				if (!ok) begin
					fr = {slave_addr, FC_READ | 8'h80, EXC_ADDRESS};
				end else begin
					fr = {slave_addr, FC_READ, 8'(qty * 2)};
					for (int i = 0; i < qty && fr.size() + 4 <= 29; i++) begin
						r = reg_value(first_reg + 16'(i), hum, tmp);
						fr.push_back(r[15:8]);
						fr.push_back(r[7:0]);
					end
				end
			end
		end else begin
			if (qty == 0 || qty > MAX_WRITE_QTY) begin
				fr = {slave_addr, FC_WRITE | 8'h80, EXC_VALUE};
			end else begin
				for (int i = 0; i < qty; i++)
					if (!reg_writable(first_reg + 16'(i))) ok = 1'b0;
				if (!ok) begin
					fr = {slave_addr, FC_WRITE | 8'h80, EXC_ADDRESS};
				end else begin
					lim = qty < 8 ? qty : 8;
					for (int i = 0; i < lim; i++) begin
						r = first_reg + 16'(i);
						if (staged_valid[i]) begin
							if (r >= ALARM_FIRST && r <= ALARM_LAST)
								alarm_words[3'(r - ALARM_FIRST)] = staged[i];
							else if (r == TEMP_CORR_REG) corr_words[0] = staged[i];
							else if (r == HUM_CORR_REG) corr_words[1] = staged[i];
						end
					end
					fr = {slave_addr, FC_WRITE, first_reg[15:8], first_reg[7:0],
						qty[15:8], qty[7:0]};
				end
			end
		end
		crc = 16'hFFFF;
		foreach (fr[i]) crc = crc_byte(crc, fr[i]);
		fr.push_back(crc[7:0]);
		fr.push_back(crc[15:8]);
		foreach (fr[i])
			expected_resp.push_back('{fr[i], i == fr.size() - 1, corr_words[0], corr_words[1]});
	endtask

	task automatic take_request(input logic [7:0] b, input logic fin, input logic [15:0] hum,
			input logic [15:0] tmp);
		int k;
		if (pos == 0) begin
			fn_code = 0; first_reg = 0; qty = 0; staged_valid = 0;
			slave_addr = b;
		end
		case (pos)
			8'd0: ;
			8'd1: fn_code = b;
			8'd2: first_reg[15:8] = b;
			8'd3: first_reg[7:0] = b;
			8'd4: qty[15:8] = b;
			8'd5: qty[7:0] = b;
			default: begin
				if (pos >= 7 && pos <= 22) begin
					k = (pos - 7) >> 1;
					if (((pos - 7) & 1) == 0) begin
						staged[k] = {b, 8'h00};
					end else begin
						staged[k][7:0] = b;
						staged_valid[k] = 1'b1;
					end
				end
			end
		endcase
		if (pos != 8'd255) pos++;
		if (fin) begin
			pos = 0;
			if (fn_code == FC_READ || fn_code == FC_WRITE) close_frame(hum, tmp);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		resp_item_t exp_item;
		int errs;
		if (!arst_n) begin
			expected_resp.delete();
			foreach (cfg_words[i]) cfg_words[i] = 0;
			foreach (alarm_words[i]) alarm_words[i] = 0;
			corr_words[0] = 0;
			corr_words[1] = 0;
			pos = 0; fn_code = 0; slave_addr = 0; first_reg = 0; qty = 0;
			staged_valid = 0;
			fail_count <= 0;
			resp_frames <= 0;
		end else begin
			errs = 0;
			if (cfg_we) cfg_words[cfg_index] = cfg_data;
			// check output first: its byte was predicted by an earlier request
			if (resp_valid && resp_ready) begin
				if (expected_resp.size() == 0) begin
					$error("unexpected response byte %h", resp_byte);
					errs++;
				end else begin
					exp_item = expected_resp.pop_front();
					if (resp_byte !== exp_item.data) begin
						$error("resp_byte expected %h actual %h", exp_item.data, resp_byte);
						errs++;
					end
					if (resp_end !== exp_item.last) begin
						$error("resp_end expected %b actual %b", exp_item.last, resp_end);
						errs++;
					end
					if (temp_correction !== exp_item.tcorr) begin
						$error("temp_correction expected %h actual %h", exp_item.tcorr,
							temp_correction);
						errs++;
					end
					if (humidity_correction !== exp_item.hcorr) begin
						$error("humidity_correction expected %h actual %h", exp_item.hcorr,
							humidity_correction);
						errs++;
					end
					if (exp_item.last) resp_frames <= resp_frames + 1;
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			if (req_valid && req_ready) take_request(req_byte, req_end, humidity, temperature);
		end
	end
endmodule
`default_nettype wire

// ===== sim/tb_modbus_sensor_register_responder.sv =====
// Testbench top for the Modbus register responder: stimulus, reset and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_modbus_sensor_register_responder;
	import msrr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [7:0] req_byte = '0;
	logic req_end = 1'b0;
	logic [15:0] humidity = '0;
	logic signed [15:0] temperature = '0;
	logic resp_valid;
	logic resp_ready = 1'b0;
	logic [7:0] resp_byte;
	logic resp_end;
	logic signed [15:0] temp_correction;
	logic signed [15:0] humidity_correction;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int fail_count;
	int pending_bytes;
	int resp_frames;
	int sender_idle_pct = 0;     // chance of a gap before a request
	int receiver_stall_pct = 0;  // chance of resp_ready low per cycle
	int request_total = 0;
	int phase_base = 0;
	longint cycle_count = 0;

	localparam longint CYCLE_LIMIT = 400000;

	always #5 clk = ~clk;

	modbus_sensor_register_responder dut (.*);

	msrr_frame_checker u_checker (.*);

	// Receiver: random back-pressure on the response channel.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		resp_ready <= ($urandom_range(99) >= receiver_stall_pct);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL modbus_sensor_register_responder");
			$finish;
		end
	end

	// Sends one request byte; holds valid until accepted, with random gaps.
	task automatic send_request(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_byte <= b;
		req_end <= fin;
		humidity <= 16'($urandom);
		temperature <= 16'($urandom);
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		request_total++;
	endtask

	task automatic finish_sending();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input logic [7:0] bytes[$]);
		foreach (bytes[i]) send_request(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic read_frame(input logic [15:0] start, input logic [15:0] cnt);
		send_frame({8'($urandom), FC_READ, start[15:8], start[7:0], cnt[15:8], cnt[7:0]});
	endtask

	// Write frame; nvals words follow the byte count, drop trims trailing bytes.
	task automatic write_frame(input logic [15:0] start, input logic [15:0] cnt,
			input int nvals, input int drop);
		logic [7:0] fr[$];
		fr = {8'($urandom), FC_WRITE, start[15:8], start[7:0], cnt[15:8], cnt[7:0],
			8'(nvals * 2)};
		for (int i = 0; i < 2 * nvals; i++) fr.push_back(8'($urandom));
		for (int i = 0; i < drop && fr.size() > 1; i++) void'(fr.pop_back());
		send_frame(fr);
	endtask

	// Wait until all predicted response bytes are out, then a short quiet time.
	task automatic drain();
		finish_sending();
		while (pending_bytes != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One config write per call; end_cfg drops the enable after a group.
	task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic end_cfg();
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed frames aimed at the register map, some noise.
	task automatic random_frame();
		int sel;
		logic [15:0] s;
		sel = $urandom_range(99);
		if (sel < 35) begin
			s = 16'($urandom_range(0, 20));
			read_frame(s, 16'($urandom_range(1, 13)));
		end else if (sel < 65) begin
			s = ($urandom_range(1) != 0) ? 16'($urandom_range(12, 19)) : 16'($urandom_range(28, 30));
			write_frame(s, 16'($urandom_range(1, 8)), $urandom_range(0, 9), $urandom_range(0, 3));
		end else if (sel < 75) begin
			if ($urandom_range(1) != 0) read_frame(16'($urandom), 16'($urandom));
			else write_frame(16'($urandom), 16'($urandom), $urandom_range(0, 3), 0);
		end else if (sel < 85) begin
			send_frame({8'($urandom), 8'($urandom), 8'($urandom)});
		end else begin
			// truncated header of a known function
			send_frame({8'($urandom), (($urandom_range(1) != 0) ? FC_READ : FC_WRITE),
				8'($urandom)});
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: config extremes, map edges, exceptions and odd frames.
		write_cfg(CFG_DEV_TYPE, 16'hFFFF);
		write_cfg(CFG_FW_VER, 16'h0000);
		write_cfg(CFG_ID_HIGH, 16'hA55A);
		write_cfg(CFG_ID_LOW, 16'h5AA5);
		end_cfg();
		read_frame(16'h0000, 16'd2);
		read_frame(16'h0008, 16'd12);
		read_frame(16'h0000, 16'd0);
		read_frame(16'h0000, 16'd126);
		read_frame(16'hFFFF, 16'd2);
		write_frame(ALARM_FIRST, 16'd8, 8, 0);
		write_frame(TEMP_CORR_REG, 16'd2, 2, 0);
		write_frame(ALARM_FIRST, 16'd4, 4, 3);
		write_frame(16'h001C, 16'd2, 2, 0);
		write_frame(ALARM_FIRST, 16'd124, 1, 0);
		write_frame(ALARM_FIRST, 16'd2, 12, 0);
		send_frame({8'hFF, 8'h04, 8'h00});
		send_frame({8'h11});
		send_frame({8'h00, FC_READ, 8'h00, 8'h0C});
		drain();

		write_cfg(CFG_DEV_TYPE, 16'h0000);
		write_cfg(CFG_FW_VER, 16'hFFFF);
		write_cfg(CFG_ID_HIGH, 16'h0000);
		write_cfg(CFG_ID_LOW, 16'hFFFF);
		end_cfg();
		read_frame(16'h0008, 16'd4);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 72; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 72; end
				default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
			endcase
			for (int i = 0; i < 4; i++) write_cfg(2'(i), 16'($urandom));
			end_cfg();
			phase_base = request_total;
			while (request_total < phase_base + 42) random_frame();
			drain();
		end

		receiver_stall_pct = 0;
		drain();
		$display("Covered %0d requests and %0d response frames: reads, writes, exceptions,",
			request_total, resp_frames);
		$display("short and long frames, unknown functions, four config settings and idling mixes.");
		if (fail_count == 0)
			$display("PASS modbus_sensor_register_responder");
		else
			$display("FAIL modbus_sensor_register_responder");
		$finish;
	end
endmodule
`default_nettype wire
